// File: src/lod_patch_index_generator_top_assert.svh
// Assertion macros for the LOD patch index generator.
// Expects clk and arst_n in the scope of each use.
`ifndef LOD_PATCH_INDEX_GENERATOR_TOP_ASSERT_SVH
`define LOD_PATCH_INDEX_GENERATOR_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LPIG_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpig: assertion failed");

// antecedent implies consequent in the next cycle
`define LPIG_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpig: assertion failed");

`endif

// File: src/lpig_pkg.sv
// Shared types, constants and the control program of the LOD patch index generator.
// No dependencies.
package lpig_pkg;

	localparam int PATCH_SIDE_DEF = 65;
	localparam int INDEX_BITS_DEF = 21;
	localparam int CENTER_W = 21;
	localparam int STRIDE_W = 13;
	localparam int STEP_W = 6;
	localparam int COORD_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 21;
	localparam int MAX_STEP = 32;
	localparam int MULB_W = STRIDE_W + 2;
	localparam int PROD_W = STEP_W + 1 + MULB_W;
	localparam int K_W = 5;
	localparam int PC_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER = 3'd0,
		CFG_MAJOR  = 3'd1,
		CFG_MINOR  = 3'd2,
		CFG_STEP   = 3'd3,
		CFG_NBR    = 3'd4,
		CFG_FLIP   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [CENTER_W-1:0]        center;
		logic signed [STRIDE_W-1:0] major;
		logic signed [STRIDE_W-1:0] minor;
		logic [STEP_W-1:0]          lod_step;
		logic [STEP_W-1:0]          nbr_step;
		logic                       flip;
	} cfg_t;

	typedef enum logic [1:0] {MA_ROW, MA_COL, MA_STEP, MA_FAN} mula_t;
	typedef enum logic [1:0] {MB_MAJOR, MB_MINOR, MB_DIAG} mulb_t;
	typedef enum logic [1:0] {AA_CENTER, AA_P00, AA_P10, AA_Q0} addsrc_t;
	typedef enum logic [2:0] {AD_P00, AD_P10, AD_P01, AD_P11, AD_Q0} adddst_t;
	typedef enum logic [1:0] {EM_NONE, EM_QUAD0, EM_QUAD1, EM_FAN} emit_t;
	typedef enum logic [2:0] {
		JC_NEXT, JC_ALWAYS, JC_WAIT_IN, JC_IF_INVALID, JC_IF_DIAG, JC_FAN_LOOP
	} cond_t;

	typedef struct packed {
		logic            latch_in;
		logic            mul_en;
		mula_t           mula;
		mulb_t           mulb;
		logic            add_en;
		addsrc_t         add_src;
		adddst_t         add_dst;
		logic            fan_init;
		emit_t           emit;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   fire;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic invalid;
		logic diag;
		logic fan_more;
	} stat_t;

	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
	localparam logic [PC_W-1:0] PC_BASE  = 4'd2;
	localparam logic [PC_W-1:0] PC_COL   = 4'd3;
	localparam logic [PC_W-1:0] PC_P10   = 4'd4;
	localparam logic [PC_W-1:0] PC_P01   = 4'd5;
	localparam logic [PC_W-1:0] PC_P11   = 4'd6;
	localparam logic [PC_W-1:0] PC_QUAD0 = 4'd7;
	localparam logic [PC_W-1:0] PC_QUAD1 = 4'd8;
	localparam logic [PC_W-1:0] PC_FAN   = 4'd9;
	localparam logic [PC_W-1:0] PC_LAST  = PC_FAN;

	localparam uword_t UW_NOP = '{
		latch_in: 1'b0, mul_en: 1'b0, mula: MA_ROW, mulb: MB_MAJOR,
		add_en: 1'b0, add_src: AA_P00, add_dst: AD_P00, fan_init: 1'b0,
		emit: EM_NONE, cond: JC_NEXT, target: PC_WAIT
	};

	// control store: one word per step
	function automatic uword_t prog_word(logic [PC_W-1:0] pc);
		uword_t w;
		w = UW_NOP;
		unique case (pc)
			PC_WAIT: begin
				w.latch_in = 1'b1;
				w.cond     = JC_WAIT_IN;
			end
			PC_CHECK: begin
				w.mul_en = 1'b1;
				w.mula   = MA_ROW;
				w.mulb   = MB_MAJOR;
				w.cond   = JC_IF_INVALID;
				w.target = PC_WAIT;
			end
			PC_BASE: begin
				w.add_en  = 1'b1;
				w.add_src = AA_CENTER;
				w.add_dst = AD_P00;
				w.mul_en  = 1'b1;
				w.mula    = MA_COL;
				w.mulb    = MB_MINOR;
			end
			PC_COL: begin
				w.add_en  = 1'b1;
				w.add_src = AA_P00;
				w.add_dst = AD_P00;
				w.mul_en  = 1'b1;
				w.mula    = MA_STEP;
				w.mulb    = MB_MAJOR;
			end
			PC_P10: begin
				w.add_en  = 1'b1;
				w.add_src = AA_P00;
				w.add_dst = AD_P10;
				w.mul_en  = 1'b1;
				w.mula    = MA_STEP;
				w.mulb    = MB_MINOR;
			end
			PC_P01: begin
				w.add_en  = 1'b1;
				w.add_src = AA_P00;
				w.add_dst = AD_P01;
			end
			PC_P11: begin
				w.add_en   = 1'b1;
				w.add_src  = AA_P10;
				w.add_dst  = AD_P11;
				w.mul_en   = 1'b1;
				w.mula     = MA_FAN;
				w.mulb     = MB_DIAG;
				w.fan_init = 1'b1;
				w.cond     = JC_IF_DIAG;
				w.target   = PC_FAN;
			end
			PC_QUAD0: begin
				w.emit = EM_QUAD0;
			end
			PC_QUAD1: begin
				w.emit   = EM_QUAD1;
				w.cond   = JC_ALWAYS;
				w.target = PC_WAIT;
			end
			PC_FAN: begin
				w.add_en  = 1'b1;
				w.add_src = AA_Q0;
				w.add_dst = AD_Q0;
				w.emit    = EM_FAN;
				w.cond    = JC_FAN_LOOP;
				w.target  = PC_WAIT;
			end
			default: begin
				w.cond   = JC_ALWAYS;
				w.target = PC_WAIT;
			end
		endcase
		return w;
	endfunction

	// zero reads as one, anything above the maximum saturates
	function automatic logic [STEP_W-1:0] clamp_step(logic [STEP_W-1:0] v);
		if (v == '0) begin
			return STEP_W'(1);
		end else if (v > STEP_W'(MAX_STEP)) begin
			return STEP_W'(MAX_STEP);
		end
		return v;
	endfunction

endpackage

// File: src/lpig_if.sv
// Valid/ready channel interfaces: cell coordinates in, triangles out, register writes.
// Depends on lpig_pkg.
interface lpig_coord_if;
	logic                          valid;
	logic                          ready;
	logic [lpig_pkg::COORD_W-1:0] row;
	logic [lpig_pkg::COORD_W-1:0] column;
	modport source (output valid, output row, output column, input ready);
	modport sink (input valid, input row, input column, output ready);
endinterface

interface lpig_tri_if #(parameter int IDX_W = lpig_pkg::INDEX_BITS_DEF);
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] corner_a;
	logic [IDX_W-1:0] corner_b;
	logic [IDX_W-1:0] corner_c;
	logic             last;
	modport source (output valid, output corner_a, output corner_b, output corner_c,
		output last, input ready);
	modport sink (input valid, input corner_a, input corner_b, input corner_c,
		input last, output ready);
endinterface

interface lpig_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lpig_pkg::CFG_IDX_W-1:0]  index;
	logic [lpig_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/lpig_seq.sv
// Step counter and control store of the index generator.
// Depends on lpig_pkg and the assertion macro header.
`include "lod_patch_index_generator_top_assert.svh"

module lpig_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  lpig_pkg::stat_t stat,
	output lpig_pkg::ctl_t  ctl
);

	logic [lpig_pkg::PC_W-1:0] step_q;
	logic [lpig_pkg::PC_W-1:0] step_nxt;
	lpig_pkg::uword_t          uw;
	logic                      fire;

	always_comb begin
		uw = lpig_pkg::prog_word(step_q);
		fire = (uw.emit == lpig_pkg::EM_NONE || stat.out_free) &&
			(uw.cond != lpig_pkg::JC_WAIT_IN || stat.in_valid);
	end

	always_comb begin
		step_nxt = step_q + lpig_pkg::PC_W'(1);
		unique case (uw.cond)
			lpig_pkg::JC_NEXT:       step_nxt = step_q + lpig_pkg::PC_W'(1);
			lpig_pkg::JC_ALWAYS:     step_nxt = uw.target;
			lpig_pkg::JC_WAIT_IN:    step_nxt = step_q + lpig_pkg::PC_W'(1);
			lpig_pkg::JC_IF_INVALID: if (stat.invalid) step_nxt = uw.target;
			lpig_pkg::JC_IF_DIAG:    if (stat.diag) step_nxt = uw.target;
			lpig_pkg::JC_FAN_LOOP:   step_nxt = stat.fan_more ? step_q : uw.target;
			default:                 step_nxt = lpig_pkg::PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lpig_pkg::PC_WAIT;
		end else if (fire) begin
			step_q <= step_nxt;
		end
	end

	assign ctl.uw = uw;
	assign ctl.fire = fire;

	`LPIG_ASSERT_IMP(a_pc_range, 1'b1, step_q <= lpig_pkg::PC_LAST)
	`LPIG_ASSERT_NXT(a_accept_moves, fire && uw.cond == lpig_pkg::JC_WAIT_IN, step_q == lpig_pkg::PC_CHECK)
	`LPIG_ASSERT_NXT(a_stall_holds, uw.emit != lpig_pkg::EM_NONE && !stat.out_free, $stable(step_q))
	`LPIG_ASSERT_IMP(a_fan_diag_only, uw.emit == lpig_pkg::EM_FAN, stat.diag && !stat.invalid)

endmodule

// File: src/lpig_dp.sv
// Datapath: cell registers, one multiplier, one index adder, corner registers, output stage.
// Depends on lpig_pkg and lpig_if.
module lpig_dp #(
	parameter int PATCH_SIDE = lpig_pkg::PATCH_SIDE_DEF,
	parameter int INDEX_BITS = lpig_pkg::INDEX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpig_pkg::cfg_t    cfg,
	input  lpig_pkg::ctl_t    ctl,
	output lpig_pkg::stat_t   stat,
	lpig_coord_if.sink        coord,
	lpig_tri_if.source        triangle
);

	localparam int HALF_SIDE = (PATCH_SIDE - 1) / 2;

	logic [lpig_pkg::COORD_W-1:0]     row_q, col_q;
	logic signed [lpig_pkg::PROD_W-1:0] prod_q;
	logic [INDEX_BITS-1:0]            p00_q, p10_q, p01_q, p11_q, q0_q;
	logic [lpig_pkg::K_W-1:0]         k_q;
	logic                             out_valid_q;
	logic [INDEX_BITS-1:0]            ca_q, cb_q, cc_q;
	logic                             last_q;

	logic [lpig_pkg::STEP_W-1:0]      s_eff, nb_eff, a_eff, mul_a;
	logic signed [lpig_pkg::MULB_W-1:0] mj, mn, mul_b;
	logic [INDEX_BITS-1:0]            add_a, sum;
	logic [lpig_pkg::STEP_W-1:0]      k_nxt;
	logic                             fan_more, out_free, emit_fire;

	always_comb begin
		s_eff = lpig_pkg::clamp_step(cfg.lod_step);
		nb_eff = lpig_pkg::clamp_step(cfg.nbr_step);
		a_eff = (s_eff < nb_eff) ? s_eff : nb_eff;
		mj = lpig_pkg::MULB_W'(cfg.major);
		mn = lpig_pkg::MULB_W'(cfg.minor);
		k_nxt = lpig_pkg::STEP_W'(k_q) + a_eff;
		fan_more = k_nxt < s_eff;
	end

	always_comb begin
		unique case (ctl.uw.mula)
			lpig_pkg::MA_ROW:  mul_a = lpig_pkg::STEP_W'(row_q);
			lpig_pkg::MA_COL:  mul_a = lpig_pkg::STEP_W'(col_q);
			lpig_pkg::MA_STEP: mul_a = s_eff;
			lpig_pkg::MA_FAN:  mul_a = a_eff;
			default:           mul_a = a_eff;
		endcase
		unique case (ctl.uw.mulb)
			lpig_pkg::MB_MAJOR: mul_b = mj;
			lpig_pkg::MB_MINOR: mul_b = mn;
			lpig_pkg::MB_DIAG:  mul_b = mj + mn;
			default:            mul_b = mj + mn;
		endcase
		unique case (ctl.uw.add_src)
			lpig_pkg::AA_CENTER: add_a = INDEX_BITS'(cfg.center);
			lpig_pkg::AA_P00:    add_a = p00_q;
			lpig_pkg::AA_P10:    add_a = p10_q;
			lpig_pkg::AA_Q0:     add_a = q0_q;
			default:             add_a = q0_q;
		endcase
		// signed product wraps into the index width
		sum = add_a + INDEX_BITS'(prod_q);
	end

	assign coord.ready = (ctl.uw.cond == lpig_pkg::JC_WAIT_IN);

	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.uw.latch_in) begin
			row_q <= coord.row;
			col_q <= coord.column;
		end
		if (ctl.fire && ctl.uw.mul_en) begin
			prod_q <= $signed({1'b0, mul_a}) * mul_b;
		end
		if (ctl.fire && ctl.uw.add_en) begin
			unique case (ctl.uw.add_dst)
				lpig_pkg::AD_P00: p00_q <= sum;
				lpig_pkg::AD_P10: p10_q <= sum;
				lpig_pkg::AD_P01: p01_q <= sum;
				lpig_pkg::AD_P11: p11_q <= sum;
				lpig_pkg::AD_Q0:  q0_q <= sum;
				default:          q0_q <= sum;
			endcase
		end
		if (ctl.fire && ctl.uw.fan_init) begin
			q0_q <= p00_q;
			k_q <= '0;
		end else if (ctl.fire && ctl.uw.emit == lpig_pkg::EM_FAN) begin
			k_q <= lpig_pkg::K_W'(k_nxt);
		end
	end

	// output stage: a triangle waits here while the next one is being prepared
	assign out_free = !out_valid_q || triangle.ready;
	assign emit_fire = ctl.fire && (ctl.uw.emit != lpig_pkg::EM_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (triangle.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			unique case (ctl.uw.emit)
				lpig_pkg::EM_QUAD0: begin
					ca_q <= p00_q;
					cb_q <= cfg.flip ? p11_q : p10_q;
					cc_q <= cfg.flip ? p10_q : p11_q;
					last_q <= 1'b0;
				end
				lpig_pkg::EM_QUAD1: begin
					ca_q <= p00_q;
					cb_q <= cfg.flip ? p01_q : p11_q;
					cc_q <= cfg.flip ? p11_q : p01_q;
					last_q <= 1'b1;
				end
				lpig_pkg::EM_FAN: begin
					ca_q <= p10_q;
					cb_q <= cfg.flip ? q0_q : sum;
					cc_q <= cfg.flip ? sum : q0_q;
					last_q <= !fan_more;
				end
				default: begin
					last_q <= last_q;
				end
			endcase
		end
	end

	assign triangle.valid = out_valid_q;
	assign triangle.corner_a = ca_q;
	assign triangle.corner_b = cb_q;
	assign triangle.corner_c = cc_q;
	assign triangle.last = last_q;

	assign stat.in_valid = coord.valid;
	assign stat.out_free = out_free;
	assign stat.invalid = (int'(row_q) >= HALF_SIDE) || (col_q > row_q);
	assign stat.diag = (row_q == col_q);
	assign stat.fan_more = fan_more;

endmodule

// File: src/lod_patch_index_generator_top.sv
// Terrain patch sector index generator: cell coordinates in, triangles out, driven by a short
// control program. A cell inside the sector below the diagonal gives two quad triangles, and a
// diagonal cell gives a fan of triangles, one per fan step; its last triangle is loaded into the
// output register as the program returns to waiting for the next cell. A cell outside the sector
// gives nothing. The program steps through the single multiplier and index adder, one product
// and one sum a cycle while it is not stalled on input or on a held triangle output. Sector
// settings are to be written through the register channel while idle; the block does not enforce it.
// Depends on lpig_pkg, lpig_if, lpig_seq, lpig_dp.
module lod_patch_index_generator_top #(
	parameter int PATCH_SIDE = lpig_pkg::PATCH_SIDE_DEF,
	parameter int INDEX_BITS = lpig_pkg::INDEX_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lpig_cfg_if.sink   cfg,
	lpig_coord_if.sink coord,
	lpig_tri_if.source triangle
);

	lpig_pkg::cfg_t  regs_q;
	lpig_pkg::ctl_t  ctl;
	lpig_pkg::stat_t stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.center <= '0;
			regs_q.major <= lpig_pkg::STRIDE_W'(1);
			regs_q.minor <= lpig_pkg::STRIDE_W'(1);
			regs_q.lod_step <= lpig_pkg::STEP_W'(1);
			regs_q.nbr_step <= lpig_pkg::STEP_W'(1);
			regs_q.flip <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lpig_pkg::CFG_CENTER: regs_q.center <= lpig_pkg::CENTER_W'(cfg.data);
				lpig_pkg::CFG_MAJOR:  regs_q.major <= lpig_pkg::STRIDE_W'(cfg.data);
				lpig_pkg::CFG_MINOR:  regs_q.minor <= lpig_pkg::STRIDE_W'(cfg.data);
				lpig_pkg::CFG_STEP:   regs_q.lod_step <= lpig_pkg::STEP_W'(cfg.data);
				lpig_pkg::CFG_NBR:    regs_q.nbr_step <= lpig_pkg::STEP_W'(cfg.data);
				lpig_pkg::CFG_FLIP:   regs_q.flip <= cfg.data[0];
				default:              regs_q <= regs_q;
			endcase
		end
	end

	lpig_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	lpig_dp #(
		.PATCH_SIDE (PATCH_SIDE),
		.INDEX_BITS (INDEX_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (regs_q),
		.ctl      (ctl),
		.stat     (stat),
		.coord    (coord),
		.triangle (triangle)
	);

endmodule
